@@ design/pan_sweep_sequencer_core_macros.svh @@
// assertion macros shared by the pan sweep sequencer checker
`ifndef PAN_SWEEP_SEQUENCER_CORE_MACROS_SVH
`define PAN_SWEEP_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pan sweep check failed");

// next-cycle implication, disabled during reset
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pan sweep check failed");

`endif

@@ design/pss_pkg.sv @@
// types, codes and constants of the pan sweep sequencer
`default_nettype none
package pss_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_ACTIVATE   = 2'd1;
    localparam logic [1:0] KIND_DEACTIVATE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_STEP_ANGLE       = 2'd0;
    localparam logic [1:0] REG_WAIT_TICKS       = 2'd1;
    localparam logic [1:0] REG_HOME_ANGLE       = 2'd2;
    localparam logic [1:0] REG_ARRIVE_TOLERANCE = 2'd3;

    // register reset values
    localparam logic [14:0]        STEP_ANGLE_RST       = 15'd1000;
    localparam logic [15:0]        WAIT_TICKS_RST       = 16'd0;
    localparam logic signed [15:0] HOME_ANGLE_RST       = 16'sd0;
    localparam logic [9:0]         ARRIVE_TOLERANCE_RST = 10'd5;

    // sweep geometry in centidegrees
    localparam int SWEEP_START  = -18000;
    localparam int SWEEP_LIMIT  = 18000;
    localparam int LIMIT_MARGIN = 500;

    // drive status bit that is set while the drive moves
    localparam int BUSY_BIT_POS = 4;

    typedef enum logic [2:0] {
        MODE_INACTIVE = 3'd0,
        MODE_INIT     = 3'd1,
        MODE_MOVING   = 3'd2,
        MODE_STOPPING = 3'd3,
        MODE_WAITING  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [14:0]        step_angle;
        logic [15:0]        wait_ticks;
        logic signed [15:0] home_angle;
        logic [9:0]         arrive_tolerance;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               status_ok;
        logic [15:0]        moving_status;
        logic               angle_ok;
        logic signed [16:0] pan_angle;
    } item_t;

    typedef struct packed {
        mode_t              mode;
        logic [15:0]        last_status;
        logic signed [15:0] target;
        logic [15:0]        dwell_left;
    } state_t;

    typedef struct packed {
        logic               accepted;
        logic               move_valid;
        logic signed [15:0] move_target;
        logic               stop_valid;
        mode_t              mode;
        logic               fault;
    } result_t;

endpackage
`default_nettype wire

@@ design/pss_cfg_regs.sv @@
// configuration register file of the pan sweep sequencer
`default_nettype none
module pss_cfg_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output pss_pkg::cfg_t     cfg
);

    pss_pkg::cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_angle       <= pss_pkg::STEP_ANGLE_RST;
            cfg_reg.wait_ticks       <= pss_pkg::WAIT_TICKS_RST;
            cfg_reg.home_angle       <= pss_pkg::HOME_ANGLE_RST;
            cfg_reg.arrive_tolerance <= pss_pkg::ARRIVE_TOLERANCE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pss_pkg::REG_STEP_ANGLE:       cfg_reg.step_angle <= cfg_data[14:0];
                pss_pkg::REG_WAIT_TICKS:       cfg_reg.wait_ticks <= cfg_data;
                pss_pkg::REG_HOME_ANGLE:       cfg_reg.home_angle <= signed'(cfg_data);
                pss_pkg::REG_ARRIVE_TOLERANCE: cfg_reg.arrive_tolerance <= cfg_data[9:0];
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/pss_step.sv @@
// next-state and result logic for one item of the pan sweep sequencer
`default_nettype none
module pss_step (
    input  wire pss_pkg::cfg_t   cfg,
    input  wire pss_pkg::state_t state,
    input  wire pss_pkg::item_t  item,
    output pss_pkg::state_t      state_next,
    output pss_pkg::result_t     result
);

    logic               settled;
    logic signed [17:0] err;
    logic [17:0]        err_abs;
    logic               arrived;
    logic signed [17:0] step_sum;
    logic               past_limit;
    logic               accepted;
    logic               move_valid;
    logic               stop_valid;
    logic               fault;
    logic               record;

    // drive settled: status unchanged and busy bit clear
    assign settled = (item.moving_status == state.last_status)
                   && !item.moving_status[pss_pkg::BUSY_BIT_POS];

    // arrival check on the absolute angle error
    assign err     = 18'(state.target) - 18'(item.pan_angle);
    assign err_abs = err[17] ? 18'(-err) : 18'(err);
    assign arrived = err_abs <= {8'd0, cfg.arrive_tolerance};

    // next step and check against the end of the sweep
    assign step_sum   = 18'(state.target) + signed'({3'd0, cfg.step_angle});
    assign past_limit = step_sum
                      > signed'(18'(pss_pkg::SWEEP_LIMIT - pss_pkg::LIMIT_MARGIN));

    // sequencing per item kind and mode
    always_comb begin
        state_next = state;
        accepted   = 1'b0;
        move_valid = 1'b0;
        stop_valid = 1'b0;
        fault      = 1'b0;
        record     = 1'b1;
        unique case (item.kind)
            pss_pkg::KIND_ACTIVATE: begin
                if (state.mode == pss_pkg::MODE_INACTIVE) begin
                    state_next.mode   = pss_pkg::MODE_INIT;
                    state_next.target = 16'(pss_pkg::SWEEP_START);
                    accepted          = 1'b1;
                end
            end
            pss_pkg::KIND_DEACTIVATE: begin
                state_next.mode = pss_pkg::MODE_INACTIVE;
                stop_valid      = 1'b1;
            end
            pss_pkg::KIND_TICK: begin
                if (state.mode != pss_pkg::MODE_INACTIVE) begin
                    if (!item.status_ok) begin
                        fault = 1'b1;
                    end else begin
                        if (settled) begin
                            unique case (state.mode)
                                pss_pkg::MODE_INIT: begin
                                    state_next.target     = 16'(pss_pkg::SWEEP_START);
                                    state_next.dwell_left = cfg.wait_ticks;
                                    state_next.mode       = pss_pkg::MODE_MOVING;
                                    move_valid            = 1'b1;
                                end
                                pss_pkg::MODE_MOVING, pss_pkg::MODE_STOPPING: begin
                                    if (!item.angle_ok) begin
                                        fault           = 1'b1;
                                        state_next.mode = pss_pkg::MODE_INACTIVE;
                                        record          = 1'b0;
                                    end else if (arrived) begin
                                        state_next.mode =
                                            (state.mode == pss_pkg::MODE_STOPPING)
                                            ? pss_pkg::MODE_INACTIVE
                                            : pss_pkg::MODE_WAITING;
                                    end
                                end
                                pss_pkg::MODE_WAITING: begin
                                    if (state.dwell_left != 16'd0) begin
                                        state_next.dwell_left = 16'(state.dwell_left - 16'd1);
                                    end else if (past_limit) begin
                                        state_next.target = cfg.home_angle;
                                        state_next.mode   = pss_pkg::MODE_STOPPING;
                                        move_valid        = 1'b1;
                                    end else begin
                                        state_next.target     = 16'(step_sum);
                                        state_next.dwell_left = cfg.wait_ticks;
                                        state_next.mode       = pss_pkg::MODE_MOVING;
                                        move_valid            = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        if (record) begin
                            state_next.last_status = item.moving_status;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // result item
    always_comb begin
        result.accepted    = accepted;
        result.move_valid  = move_valid;
        result.move_target = move_valid ? state_next.target : 16'sd0;
        result.stop_valid  = stop_valid;
        result.mode        = state_next.mode;
        result.fault       = fault;
    end

endmodule
`default_nettype wire

@@ design/pan_sweep_sequencer_core.sv @@
// Pan sweep sequencer top level. Takes one item per clock cycle, back to back, while the
// result side does not stall, and gives one result per item: the item is captured in an
// input register, the step logic reads the sweep state and the item combinationally, and
// the result register holds the answer while the sweep state is updated at the same edge.
// Throughput is set by that single state update, one item per cycle; a stalled result
// side holds both registers and drops s_tready only when both are full. Configuration
// writes on cfg_* are taken in any cycle and should be made only while no item is in
// flight.
`default_nettype none
module pan_sweep_sequencer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // status_ok[0], moving_status[16:1], angle_ok[17], pan_angle[34:18], zero[39:35]
    input  wire logic [39:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // accepted[0], move_valid[1], move_target[17:2], stop_valid[18], mode[21:19],
    // fault[22], zero[23]
    output logic [23:0]      m_tdata,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    pss_pkg::cfg_t    cfg;
    pss_pkg::item_t   item_reg;
    logic             in_valid_reg;
    pss_pkg::state_t  state_reg;
    pss_pkg::state_t  state_next;
    pss_pkg::result_t result_next;
    pss_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             advance;

    pss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pss_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // control and sweep state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.mode        <= pss_pkg::MODE_INACTIVE;
            state_reg.last_status <= 16'd0;
            state_reg.target      <= 16'sd0;
            state_reg.dwell_left  <= 16'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    // input payload register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind          <= s_tuser;
            item_reg.status_ok     <= s_tdata[0];
            item_reg.moving_status <= s_tdata[16:1];
            item_reg.angle_ok      <= s_tdata[17];
            item_reg.pan_angle     <= signed'(s_tdata[34:18]);
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    // result transfer packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg.fault, result_reg.mode, result_reg.stop_valid,
                       result_reg.move_target, result_reg.move_valid, result_reg.accepted};

endmodule
`default_nettype wire

@@ design/pss_checker.sv @@
// port-level checks of the pan sweep sequencer, bound to the top level
`default_nettype none
`include "pan_sweep_sequencer_core_macros.svh"
module pss_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic       res_accepted;
    logic       res_move_valid;
    logic [15:0] res_target;
    logic       res_stop_valid;
    logic [2:0] res_mode;
    logic       res_fault;

    assign res_accepted   = m_tdata[0];
    assign res_move_valid = m_tdata[1];
    assign res_target     = m_tdata[17:2];
    assign res_stop_valid = m_tdata[18];
    assign res_mode       = m_tdata[21:19];
    assign res_fault      = m_tdata[22];

    // a taken activate always leaves the sweep in init
    `PSS_ASSERT_IMPLY(a_accept_init, aclk, aresetn, m_tvalid && res_accepted,
        res_mode == pss_pkg::MODE_INIT)
    // a stop always leaves the sweep inactive
    `PSS_ASSERT_IMPLY(a_stop_inactive, aclk, aresetn, m_tvalid && res_stop_valid,
        res_mode == pss_pkg::MODE_INACTIVE && !res_move_valid)
    // no commanded move means a zero target, and a fault never commands a move
    `PSS_ASSERT_IMPLY(a_target_idle, aclk, aresetn, m_tvalid && (!res_move_valid || res_fault),
        res_target == 16'd0)
    // a stalled result holds
    `PSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

endmodule

bind pan_sweep_sequencer_core pss_checker u_pss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ bench/tb_pan_sweep_sequencer_core.sv @@
// self-checking testbench for the pan sweep sequencer core, with its own sweep predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_pan_sweep_sequencer_core;
    import pss_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [15:0] BUSY_MASK   = 16'h0001 << BUSY_BIT_POS;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // predicted sweep state and register copies
    mode_t              pred_mode;
    logic [15:0]        pred_last_status;
    logic signed [15:0] pred_target;
    logic [15:0]        pred_dwell;
    cfg_t               pred_cfg;

    result_t expected_results[$];
    result_t got_result;
    result_t want_result;
    int      error_count    = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_left      = 0;
    logic [15:0] plant_status = '0;

    pan_sweep_sequencer_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** pan_sweep_sequencer_core: FAILED **");
            $finish;
        end
    end

    // result side readiness: long hold-off when requested, else random stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.accepted    = m_tdata[0];
            got_result.move_valid  = m_tdata[1];
            got_result.move_target = m_tdata[17:2];
            got_result.stop_valid  = m_tdata[18];
            got_result.mode        = mode_t'(m_tdata[21:19]);
            got_result.fault       = m_tdata[22];
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.accepted !== want_result.accepted)
                    report_field("accepted", want_result.accepted, got_result.accepted);
                if (got_result.move_valid !== want_result.move_valid)
                    report_field("move_valid", want_result.move_valid, got_result.move_valid);
                if (got_result.move_target !== want_result.move_target)
                    report_field("move_target", want_result.move_target,
                                 got_result.move_target);
                if (got_result.stop_valid !== want_result.stop_valid)
                    report_field("stop_valid", want_result.stop_valid, got_result.stop_valid);
                if (got_result.mode !== want_result.mode)
                    report_field("mode", want_result.mode, got_result.mode);
                if (got_result.fault !== want_result.fault)
                    report_field("fault", want_result.fault, got_result.fault);
            end
        end
    end

    // sweep predictor: advances the state by one item and returns its result
    function automatic result_t sweep_step(input item_t it);
        result_t r;
        logic    record;
        int      err;
        r = '0;
        case (it.kind)
            KIND_ACTIVATE: begin
                if (pred_mode == MODE_INACTIVE) begin
                    pred_mode   = MODE_INIT;
                    pred_target = 16'(SWEEP_START);
                    r.accepted  = 1'b1;
                end
            end
            KIND_DEACTIVATE: begin
                pred_mode    = MODE_INACTIVE;
                r.stop_valid = 1'b1;
            end
            KIND_TICK: begin
                if (pred_mode != MODE_INACTIVE) begin
                    if (!it.status_ok) begin
                        r.fault = 1'b1;
                    end else begin
                        record = 1'b1;
                        // act only when the drive has settled
                        if (it.moving_status == pred_last_status &&
                            (it.moving_status & BUSY_MASK) == '0) begin
                            case (pred_mode)
                                MODE_INIT: begin
                                    pred_target  = 16'(SWEEP_START);
                                    pred_dwell   = pred_cfg.wait_ticks;
                                    pred_mode    = MODE_MOVING;
                                    r.move_valid = 1'b1;
                                end
                                MODE_MOVING, MODE_STOPPING: begin
                                    if (!it.angle_ok) begin
                                        r.fault   = 1'b1;
                                        pred_mode = MODE_INACTIVE;
                                        record    = 1'b0;
                                    end else begin
                                        err = int'(pred_target) - int'($signed(it.pan_angle));
                                        if (err < 0)
                                            err = -err;
                                        if (err <= int'(pred_cfg.arrive_tolerance))
                                            pred_mode = (pred_mode == MODE_STOPPING) ?
                                                        MODE_INACTIVE : MODE_WAITING;
                                    end
                                end
                                MODE_WAITING: begin
                                    if (pred_dwell != 0) begin
                                        pred_dwell = pred_dwell - 1'b1;
                                    end else if (int'(pred_target) + int'(pred_cfg.step_angle)
                                                 + LIMIT_MARGIN > SWEEP_LIMIT) begin
                                        pred_target  = pred_cfg.home_angle;
                                        pred_mode    = MODE_STOPPING;
                                        r.move_valid = 1'b1;
                                    end else begin
                                        pred_target  = 16'(int'(pred_target) +
                                                           int'(pred_cfg.step_angle));
                                        pred_dwell   = pred_cfg.wait_ticks;
                                        pred_mode    = MODE_MOVING;
                                        r.move_valid = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        if (record)
                            pred_last_status = it.moving_status;
                    end
                end
            end
            default: ;
        endcase
        r.mode = pred_mode;
        if (r.move_valid)
            r.move_target = pred_target;
        return r;
    endfunction

    function automatic item_t make_item(input logic [1:0] kind, input logic status_ok,
                                        input logic [15:0] status, input logic angle_ok,
                                        input int angle);
        item_t it;
        it.kind          = kind;
        it.status_ok     = status_ok;
        it.moving_status = status;
        it.angle_ok      = angle_ok;
        it.pan_angle     = 17'(angle);
        return it;
    endfunction

    // offer one item, with random idle cycles ahead of it, and predict it on transfer
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {5'b0, it.pan_angle, it.angle_ok, it.moving_status, it.status_ok};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(sweep_step(it));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one register write; valid stays high for a following write
    task automatic cfg_write(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_STEP_ANGLE:       pred_cfg.step_angle       = data[14:0];
            REG_WAIT_TICKS:       pred_cfg.wait_ticks       = data;
            REG_HOME_ANGLE:       pred_cfg.home_angle       = data;
            REG_ARRIVE_TOLERANCE: pred_cfg.arrive_tolerance = data[9:0];
            default: ;
        endcase
    endtask

    task automatic set_sweep_config(input int step, input int dwell, input int home,
                                    input int tol);
        drain_results();
        cfg_write(REG_STEP_ANGLE, 16'(step));
        cfg_write(REG_WAIT_TICKS, 16'(dwell));
        cfg_write(REG_HOME_ANGLE, 16'(home));
        cfg_write(REG_ARRIVE_TOLERANCE, 16'(tol));
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed sweep traffic that follows the drive, with some noise
    task automatic pick_sweep_item(output item_t it);
        logic [63:0] raw;
        int          r;
        int          tol;
        int          angle;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 8) begin
            it = raw[36:0];
            return;
        end
        it.status_ok = ($urandom_range(99) >= 3);
        it.angle_ok  = ($urandom_range(99) >= 3);
        // drive status: steady most of the time, sometimes new or busy
        r = $urandom_range(99);
        if (r < 6)
            plant_status = raw[15:0] & ~BUSY_MASK;
        it.moving_status = (r >= 6 && r < 13) ? (plant_status | BUSY_MASK) : plant_status;
        // measured angle near the target, just outside tolerance, or anywhere
        tol = int'(pred_cfg.arrive_tolerance);
        r   = $urandom_range(99);
        if (r < 70)
            angle = int'(pred_target) - tol + int'($urandom_range(2 * tol));
        else if (r < 80)
            angle = int'(pred_target) + (r[0] ? tol + 1 : -tol - 1);
        else
            angle = int'($urandom_range(72000)) - 36000;
        it.pan_angle = 17'(angle);
        r = $urandom_range(99);
        if (pred_mode == MODE_INACTIVE)
            it.kind = (r < 80) ? KIND_ACTIVATE : (r < 90) ? KIND_TICK :
                      (r < 95) ? KIND_DEACTIVATE : KIND_UNUSED;
        else
            it.kind = (r < 3) ? KIND_DEACTIVATE : (r < 5) ? KIND_ACTIVATE :
                      (r < 6) ? KIND_UNUSED : KIND_TICK;
    endtask

    // kinds while inactive, activate handshake, settling rules, arrival and read faults
    task automatic test_sweep_basics();
        set_sweep_config(1000, 0, 0, 5);
        send_item(make_item(KIND_TICK, 1'b1, 16'hFFFF, 1'b1, 65535));
        send_item(make_item(KIND_UNUSED, 1'b1, 16'h0000, 1'b1, -65536));
        send_item(make_item(KIND_DEACTIVATE, 1'b0, 16'h0000, 1'b0, 0));
        send_item(make_item(KIND_ACTIVATE, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_ACTIVATE, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b0, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, BUSY_MASK, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, BUSY_MASK, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b0, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, -17994));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, -17995));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b0, -17000));
        send_item(make_item(KIND_UNUSED, 1'b1, 16'h0000, 1'b1, 0));
    endtask

    // dwell countdown, return home near the limit, stopping and exact tolerance
    task automatic test_dwell_and_return();
        set_sweep_config(18000, 2, -18000, 0);
        send_item(make_item(KIND_ACTIVATE, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, -18000));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        repeat (3) send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, 0));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, -18001));
        send_item(make_item(KIND_TICK, 1'b1, 16'h0000, 1'b1, -18000));
    endtask

    task automatic test_random_sweeps(input int count, input int idle_pct,
                                      input int stall_pct, input int step, input int dwell,
                                      input int home, input int tol);
        item_t it;
        set_sweep_config(step, dwell, home, tol);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            pick_sweep_item(it);
            send_item(it);
        end
    endtask

    // result side held off so the block fills up, then the sender waits for all results
    task automatic test_backpressure(input int count);
        item_t it;
        set_sweep_config(2500, 1, 9000, 200);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (count / 2) begin
            pick_sweep_item(it);
            send_item(it);
        end
        drain_results();
        repeat (count - count / 2) begin
            pick_sweep_item(it);
            send_item(it);
        end
    endtask

    initial begin
        pred_mode        = MODE_INACTIVE;
        pred_last_status = '0;
        pred_target      = '0;
        pred_dwell       = '0;
        pred_cfg         = {STEP_ANGLE_RST, WAIT_TICKS_RST, HOME_ANGLE_RST,
                            ARRIVE_TOLERANCE_RST};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sweep_basics();
        test_dwell_and_return();
        test_random_sweeps(190, 0, 0, 1000, 0, 0, 5);
        test_random_sweeps(190, 64, 0, 3000, 3, 18000, 1000);
        test_random_sweeps(190, 0, 64, 18000, 65535, -18000, 0);
        test_random_sweeps(190, 27, 27, $urandom_range(6000, 400), $urandom_range(3),
                           int'($urandom_range(36000)) - 18000, $urandom_range(1000));
        test_random_sweeps(40, 27, 27, 1, 0, 18000, 1000);
        test_backpressure(60);
        drain_results();
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("** pan_sweep_sequencer_core: PASSED **");
        else
            $display("** pan_sweep_sequencer_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
